FILE: hw/rtl/pbcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbcg_pkg
// Shared types and constants for the brightness, contrast and gamma core.
// ----------------------------------------------------------------------------
package pbcg_pkg;

   localparam int unsigned PIX_W    = 8;
   localparam int unsigned OFFSET_W = 9;
   localparam int unsigned GAIN_W   = 12;
   localparam int unsigned PROD_W   = 22;
   localparam int unsigned CSR_AW   = 4;
   localparam int unsigned CSR_DW   = 32;

   typedef logic [PIX_W-1:0]           pixel_type;
   typedef logic signed [OFFSET_W-1:0] offset_type;
   typedef logic [GAIN_W-1:0]          gain_type;
   typedef logic signed [PROD_W-1:0]   prod_type;

   // register indexes on the CSR port (byte address = 4 * index)
   localparam logic [1:0] CSR_IDX_OFFSET = 2'd0;
   localparam logic [1:0] CSR_IDX_GAIN   = 2'd1;
   localparam logic [1:0] CSR_IDX_GAMMA  = 2'd2;

   // item kinds
   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_TABLE = 1'b1;

   localparam offset_type OFFSET_RESET = 9'sd0;
   localparam gain_type   GAIN_RESET   = 12'd256;

   // contrast math in units of 1/256
   localparam logic signed [8:0] PIX_MID = 9'sd128;
   localparam prod_type MID_Q  = 22'sd32768;
   localparam prod_type SAT_Q  = 22'sd65280;
   localparam logic [16:0] HALF_Q = 17'd128;
   localparam pixel_type PIX_MAX = 8'd255;
   localparam pixel_type PIX_MIN = 8'd0;

endpackage

FILE: hw/rtl/pixel_brightness_contrast_gamma_core.sv
`timescale 1ns / 1ps
// Throughput: one beat per cycle unless rsp_stall holds, pixels and table writes alike;
//   a pixel beat passes four register stages (offset clamp, gain multiply, round and
//   clamp, gamma table read), each holding one beat, before it is presented on rsp.
// Reset clears all stage valid bits and the CSRs; the gamma table is not cleared
//   and reads as garbage until each entry is written.
// ----------------------------------------------------------------------------
// pixel_brightness_contrast_gamma_core
// Grey pixel point operation: signed brightness offset, Q4.8 contrast gain
// about mid-grey, optional 256-entry gamma lookup loaded by table-write beats.
// ----------------------------------------------------------------------------
module pixel_brightness_contrast_gamma_core (
   input  logic                        clock,
   input  logic                        reset,
   // input beats
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_kind,
   input  pbcg_pkg::pixel_type         req_pixel_in,
   input  logic                        req_row_last,
   input  pbcg_pkg::pixel_type         req_table_index,
   input  pbcg_pkg::pixel_type         req_table_value,
   // result beats
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output pbcg_pkg::pixel_type         rsp_pixel_out,
   output logic                        rsp_row_last_out,
   // CSR port
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [pbcg_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [pbcg_pkg::CSR_DW-1:0] csr_pwdata,
   output logic [pbcg_pkg::CSR_DW-1:0] csr_prdata,
   output logic                        csr_pready
);
   import pbcg_pkg::*;

   // ---------------- CSRs ----------------
   offset_type offset_ff, offset_in;
   gain_type   gain_ff, gain_in;
   logic       gamma_en_ff, gamma_en_in;
   logic [1:0] csr_idx;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      offset_in   = offset_ff;
      gain_in     = gain_ff;
      gamma_en_in = gamma_en_ff;
      if (csr_wr) begin
         case (csr_idx)
            CSR_IDX_OFFSET: offset_in   = csr_pwdata[OFFSET_W-1:0];
            CSR_IDX_GAIN:   gain_in     = csr_pwdata[GAIN_W-1:0];
            CSR_IDX_GAMMA:  gamma_en_in = csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_IDX_OFFSET: csr_prdata = {{(CSR_DW-OFFSET_W){offset_ff[OFFSET_W-1]}}, offset_ff};
         CSR_IDX_GAIN:   csr_prdata = {{(CSR_DW-GAIN_W){1'b0}}, gain_ff};
         CSR_IDX_GAMMA:  csr_prdata = {{(CSR_DW-1){1'b0}}, gamma_en_ff};
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff   <= OFFSET_RESET;
         gain_ff     <= GAIN_RESET;
         gamma_en_ff <= 1'b0;
      end else begin
         offset_ff   <= offset_in;
         gain_ff     <= gain_in;
         gamma_en_ff <= gamma_en_in;
      end
   end

   // ---------------- pipeline control ----------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic en1, en2, en3, en4;

   // a stage advances when its successor is empty or advancing
   assign en4 = !s4_valid_ff || !rsp_stall;
   assign en3 = !s3_valid_ff || en4;
   assign en2 = !s2_valid_ff || en3;
   assign en1 = !s1_valid_ff || en2;
   assign req_stall = !en1;

   // ---------------- stage 1: brightness offset and clamp ----------------
   logic signed [9:0] bsum;
   pixel_type         s1_pix_ff, s1_pix_in;
   logic              s1_kind_ff, s1_row_ff;
   pixel_type         s1_idx_ff, s1_val_ff;

   assign bsum = $signed({2'b00, req_pixel_in}) + $signed({offset_ff[OFFSET_W-1], offset_ff});

   always_comb begin
      if (bsum[9])      s1_pix_in = PIX_MIN;
      else if (bsum[8]) s1_pix_in = PIX_MAX;
      else              s1_pix_in = bsum[7:0];
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_pix_ff  <= s1_pix_in;
         s1_kind_ff <= req_kind;
         s1_row_ff  <= req_row_last;
         s1_idx_ff  <= req_table_index;
         s1_val_ff  <= req_table_value;
      end
   end

   // ---------------- stage 2: gain times distance from mid-grey ----------------
   logic signed [8:0] diff;
   prod_type          s2_prod_ff, s2_prod_in;
   logic              s2_kind_ff, s2_row_ff;
   pixel_type         s2_idx_ff, s2_val_ff;

   assign diff       = $signed({1'b0, s1_pix_ff}) - PIX_MID;
   assign s2_prod_in = prod_type'($signed({1'b0, gain_ff})) * prod_type'(diff);

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_prod_ff <= s2_prod_in;
         s2_kind_ff <= s1_kind_ff;
         s2_row_ff  <= s1_row_ff;
         s2_idx_ff  <= s1_idx_ff;
         s2_val_ff  <= s1_val_ff;
      end
   end

   // ---------------- stage 3: re-center, clamp, round half up ----------------
   prod_type    vq;
   logic [16:0] rnd;
   pixel_type   s3_pix_ff, s3_pix_in;
   logic        s3_kind_ff, s3_row_ff;
   pixel_type   s3_idx_ff, s3_val_ff;

   assign vq  = s2_prod_ff + MID_Q;
   assign rnd = vq[16:0] + HALF_Q;

   always_comb begin
      if (vq[PROD_W-1])  s3_pix_in = PIX_MIN;
      else if (vq > SAT_Q) s3_pix_in = PIX_MAX;
      else               s3_pix_in = rnd[15:8];
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_pix_ff  <= s3_pix_in;
         s3_kind_ff <= s2_kind_ff;
         s3_row_ff  <= s2_row_ff;
         s3_idx_ff  <= s2_idx_ff;
         s3_val_ff  <= s2_val_ff;
      end
   end

   // ---------------- stage valid bits ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (en1) s1_valid_ff <= req_valid;
         if (en2) s2_valid_ff <= s1_valid_ff;
         if (en3) s3_valid_ff <= s2_valid_ff;
         // table writes end at the memory stage
         if (en4) s4_valid_ff <= s3_valid_ff && (s3_kind_ff == KIND_PIXEL);
      end
   end

   // ---------------- stage 4: gamma table access ----------------
   pixel_type gamma_mem [256];
   pixel_type s4_gam_ff, s4_pix_ff;
   logic      s4_row_ff;

   // writes and reads happen here in beat order, so a later pixel sees earlier writes
   always_ff @(posedge clock) begin
      if (en4 && s3_valid_ff) begin
         if (s3_kind_ff == KIND_TABLE) gamma_mem[s3_idx_ff] <= s3_val_ff;
         else                          s4_gam_ff <= gamma_mem[s3_pix_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_pix_ff <= s3_pix_ff;
         s4_row_ff <= s3_row_ff;
      end
   end

   assign rsp_valid        = s4_valid_ff;
   assign rsp_pixel_out    = gamma_en_ff ? s4_gam_ff : s4_pix_ff;
   assign rsp_row_last_out = s4_row_ff;

   // ---------------- assertions ----------------
   a_stall_needs_beat: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with empty first stage");

   a_write_no_result: assert property (@(posedge clock) disable iff (reset)
      (s3_valid_ff && s3_kind_ff == KIND_TABLE && en4) |=> !rsp_valid)
      else $error("table write produced a result beat");

   a_stage2_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !en3) |=> (s2_valid_ff && $stable(s2_prod_ff)))
      else $error("stalled product stage lost or changed its beat");

endmodule
